FILE: hw/rtl/i2cmbe_pkg.sv
// shared types and constants for the i2c master bit engine
// no dependencies; imported by i2c_master_bit_engine_core
package i2cmbe_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE);

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // command codes as carried in the request; codes 1 to 6 double as the active primitive
  typedef enum logic [CMD_W-1:0] {
    OP_IDLE    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_SEND    = 3'd3,
    OP_WAITACK = 3'd4,
    OP_SENDACK = 3'd5,
    OP_RECV    = 3'd6,
    OP_UNUSED  = 3'd7
  } op_e;

  // command code 0 is a delay-slot tick
  localparam op_e CMD_TICK = OP_IDLE;

  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

endpackage

FILE: hw/rtl/i2c_master_bit_engine_core.sv
// i2c master line engine: start/stop/byte/ack primitives paced by tick requests
// depends on i2cmbe_pkg
//
//  channel  | dir | tdata fields (lsb first)                            | tlast/tuser
//  s_axis   | in  | cmd[3] tx_byte[8] ack_level[1] sda_in[1] pad[3]     | none
//  m_axis   | out | scl sda busy rx_data[8] ack_seen done rejected pad2 | none
//
// every request is turned into one result: the state update
// and the result word come from one combinational step off the engine registers
// and land in the output register at the same edge.
// a new request is taken each cycle while the output register is empty or drained.
// reset leaves the engine idle with both lines released and no result pending.
// a stalled master side holds the result and back-pressures the slave side.
module i2c_master_bit_engine_core
  import i2cmbe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // cmd[2:0] tx_byte[10:3] ack_level[11] sda_in[12] zero[15:13]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // scl_level[0] sda_level[1] busy_res[2] rx_data[10:3] ack_seen[11]
  // done_res[12] rejected[13] zero[15:14]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  op_e               op_q, op_d;
  logic [1:0]        phase_q, phase_d;
  bit_cnt_t          bit_q, bit_d;
  logic [BYTE_W-1:0] tx_q, tx_d;
  logic [BYTE_W-1:0] rx_q, rx_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_q, ack_d;

  logic                  out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [CMD_W-1:0]  in_cmd;
  logic [BYTE_W-1:0] in_tx;
  logic              in_ack_lvl;
  logic              in_sda;
  logic              accept;
  logic              done;
  logic              rej;
  logic              last_bit;

  assign in_cmd     = s_axis_tdata_i[2:0];
  assign in_tx      = s_axis_tdata_i[10:3];
  assign in_ack_lvl = s_axis_tdata_i[11];
  assign in_sda     = s_axis_tdata_i[12];

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign last_bit        = (bit_q == bit_cnt_t'(BITS_PER_BYTE - 1));

  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    done    = 1'b0;
    rej     = 1'b0;

    case (op_e'(in_cmd))
      CMD_TICK: begin
        case (op_q)
          OP_START: begin
            if (phase_q == 2'd0) begin
              sda_d   = 1'b0;
              phase_d = 2'd1;
            end else begin
              scl_d = 1'b0;
              done  = 1'b1;
            end
          end
          OP_STOP: begin
            if (phase_q == 2'd0) begin
              sda_d   = 1'b1;
              phase_d = 2'd1;
            end else begin
              done = 1'b1;
            end
          end
          OP_SEND: begin
            case (phase_q)
              2'd0: begin
                sda_d   = tx_q[BYTE_W-1];
                phase_d = 2'd1;
              end
              2'd1: begin
                scl_d   = 1'b1;
                tx_d    = {tx_q[BYTE_W-2:0], 1'b0};
                phase_d = 2'd2;
              end
              default: begin
                scl_d = 1'b0;
                if (last_bit) begin
                  done = 1'b1;
                end else begin
                  bit_d   = bit_q + bit_cnt_t'(1);
                  phase_d = 2'd0;
                end
              end
            endcase
          end
          OP_WAITACK: begin
            if (phase_q == 2'd0) begin
              ack_d   = in_sda;
              scl_d   = 1'b0;
              phase_d = 2'd1;
            end else begin
              done = 1'b1;
            end
          end
          OP_SENDACK: begin
            case (phase_q)
              2'd0: begin
                scl_d   = 1'b1;
                phase_d = 2'd1;
              end
              2'd1: begin
                scl_d   = 1'b0;
                sda_d   = 1'b1;
                phase_d = 2'd2;
              end
              default: begin
                done = 1'b1;
              end
            endcase
          end
          OP_RECV: begin
            if (phase_q == 2'd0) begin
              rx_d    = {rx_q[BYTE_W-2:0], in_sda};
              scl_d   = 1'b0;
              phase_d = 2'd1;
            end else if (last_bit) begin
              done = 1'b1;
            end else begin
              scl_d   = 1'b1;
              bit_d   = bit_q + bit_cnt_t'(1);
              phase_d = 2'd0;
            end
          end
          default: begin
            // idle tick does nothing
          end
        endcase
        if (done) begin
          op_d    = OP_IDLE;
          phase_d = 2'd0;
          bit_d   = '0;
        end
      end
      OP_START, OP_STOP, OP_SEND, OP_WAITACK, OP_SENDACK, OP_RECV: begin
        if (op_q != OP_IDLE) begin
          rej = 1'b1;
        end else begin
          op_d    = op_e'(in_cmd);
          phase_d = 2'd0;
          bit_d   = '0;
          case (op_e'(in_cmd))
            OP_START: begin
              sda_d = 1'b1;
              scl_d = 1'b1;
            end
            OP_STOP: begin
              sda_d = 1'b0;
              scl_d = 1'b1;
            end
            OP_SEND: begin
              tx_d  = in_tx;
              scl_d = 1'b0;
            end
            OP_SENDACK: begin
              sda_d = in_ack_lvl;
              scl_d = 1'b0;
            end
            OP_RECV: begin
              rx_d  = '0;
              sda_d = 1'b1;
              scl_d = 1'b1;
            end
            default: begin
              // wait-ack: release sda so the slave can drive it
              sda_d = 1'b1;
              scl_d = 1'b1;
            end
          endcase
        end
      end
      default: begin
        // unused code, ignored without a reject
      end
    endcase

    out_data_d = {2'b00, rej, done, ack_d, rx_d, (op_d != OP_IDLE), sda_d, scl_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_IDLE;
      phase_q   <= 2'd0;
      bit_q     <= '0;
      tx_q      <= '0;
      rx_q      <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      ack_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        op_q    <= op_d;
        phase_q <= phase_d;
        bit_q   <= bit_d;
        tx_q    <= tx_d;
        rx_q    <= rx_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        ack_q   <= ack_d;
      end
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: test/tb_i2c_master_bit_engine_core.sv
// testbench for the i2c master bit engine: directed and random requests with
// a predictor of the line levels and per-request result checking
// depends on i2cmbe_pkg and i2c_master_bit_engine_core
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine_core;
  import i2cmbe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  // same order as the result word, lowest bit last
  typedef struct packed {
    logic       rejected;
    logic       done;
    logic       ack_seen;
    logic [7:0] rx_data;
    logic       busy;
    logic       sda;
    logic       scl;
  } line_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // predicted engine state
  op_e        eng_op = OP_IDLE;
  logic [4:0] eng_slot = '0;
  logic [7:0] eng_tx = '0;
  logic [7:0] eng_rx = '0;
  logic       eng_scl = 1'b1;
  logic       eng_sda = 1'b1;
  logic       eng_ack = 1'b0;

  line_result_t expected_lines[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_left = 0;
  int requests_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  i2c_master_bit_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic line_result_t advance_line_engine(op_e cmd, logic [7:0] txb,
                                                       logic ackl, logic sdai);
    line_result_t r;
    logic fin;
    logic rej;
    fin = 1'b0;
    rej = 1'b0;
    if (cmd == CMD_TICK) begin
      if (eng_op != OP_IDLE) begin
        case (eng_op)
          OP_START: begin
            if (eng_slot == 0) eng_sda = 1'b0;
            else begin
              eng_scl = 1'b0;
              fin = 1'b1;
            end
          end
          OP_STOP: begin
            if (eng_slot == 0) eng_sda = 1'b1;
            else fin = 1'b1;
          end
          OP_SEND: begin
            // three slots per bit: data, clock high and shift, clock low
            case (eng_slot % 3)
              0: eng_sda = eng_tx[7];
              1: begin
                eng_scl = 1'b1;
                eng_tx = eng_tx << 1;
              end
              default: begin
                eng_scl = 1'b0;
                if (eng_slot >= 3 * BITS_PER_BYTE - 1) fin = 1'b1;
              end
            endcase
          end
          OP_WAITACK: begin
            if (eng_slot == 0) begin
              eng_ack = sdai;
              eng_scl = 1'b0;
            end else fin = 1'b1;
          end
          OP_SENDACK: begin
            if (eng_slot == 0) eng_scl = 1'b1;
            else if (eng_slot == 1) begin
              eng_scl = 1'b0;
              eng_sda = 1'b1;
            end else fin = 1'b1;
          end
          OP_RECV: begin
            if (!eng_slot[0]) begin
              eng_rx = {eng_rx[6:0], sdai};
              eng_scl = 1'b0;
            end else if (eng_slot >= 2 * BITS_PER_BYTE - 1) fin = 1'b1;
            else eng_scl = 1'b1;
          end
          default: ;
        endcase
        if (fin) begin
          eng_op = OP_IDLE;
          eng_slot = '0;
        end else begin
          eng_slot = eng_slot + 5'd1;
        end
      end
    end else if (cmd != OP_UNUSED) begin
      if (eng_op != OP_IDLE) rej = 1'b1;
      else begin
        eng_op = cmd;
        eng_slot = '0;
        case (cmd)
          OP_START: begin
            eng_sda = 1'b1;
            eng_scl = 1'b1;
          end
          OP_STOP: begin
            eng_sda = 1'b0;
            eng_scl = 1'b1;
          end
          OP_SEND: begin
            eng_tx = txb;
            eng_scl = 1'b0;
          end
          OP_WAITACK: begin
            eng_sda = 1'b1;
            eng_scl = 1'b1;
          end
          OP_SENDACK: begin
            eng_scl = 1'b0;
            eng_sda = ackl;
          end
          default: begin
            eng_rx = '0;
            eng_sda = 1'b1;
            eng_scl = 1'b1;
          end
        endcase
      end
    end
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.busy = (eng_op != OP_IDLE);
    r.rx_data = eng_rx;
    r.ack_seen = eng_ack;
    r.done = fin;
    r.rejected = rej;
    return r;
  endfunction

  // predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_lines.push_back(advance_line_engine(op_e'(s_axis_tdata_i[2:0]),
                                                   s_axis_tdata_i[10:3],
                                                   s_axis_tdata_i[11],
                                                   s_axis_tdata_i[12]));
      requests_taken++;
    end
  end

  task automatic report_failure(string what, line_result_t want, line_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected scl %b sda %b busy %b rx %h ack %b done %b rej %b",
               $realtime, what, want.scl, want.sda, want.busy, want.rx_data,
               want.ack_seen, want.done, want.rejected);
      $display("    got scl %b sda %b busy %b rx %h ack %b done %b rej %b",
               got.scl, got.sda, got.busy, got.rx_data, got.ack_seen, got.done,
               got.rejected);
    end
  endtask

  always @(posedge clk_i) begin
    line_result_t got;
    line_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = line_result_t'(m_axis_tdata_o[13:0]);
      if (expected_lines.size() == 0) begin
        report_failure("result with nothing expected", '0, got);
      end else begin
        want = expected_lines.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
            got.rx_data !== want.rx_data || got.ack_seen !== want.ack_seen ||
            got.done !== want.done || got.rejected !== want.rejected)
          report_failure("line result mismatch", want, got);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(op_e cmd, logic [7:0] txb, logic ackl, logic sdai);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {3'b000, sdai, ackl, txb, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // wait on the clock before the first check so the last accepted request is already in the queue
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_lines.size() != 0);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic tick(logic sdai);
    send_request(CMD_TICK, 8'($urandom), 1'($urandom), sdai);
  endtask

  task automatic test_idle_codes();
    tick(1'b1);
    send_request(OP_UNUSED, 8'hFF, 1'b1, 1'b1);
    tick(1'b0);
  endtask

  task automatic test_start_stop_and_reject();
    send_request(OP_START, 8'h00, 1'b0, 1'b0);
    send_request(OP_RECV, 8'hFF, 1'b1, 1'b1);
    tick(1'b1);
    send_request(OP_UNUSED, 8'h00, 1'b0, 1'b0);
    tick(1'b0);
    send_request(OP_STOP, 8'hFF, 1'b1, 1'b1);
    tick(1'b0);
    tick(1'b1);
  endtask

  task automatic test_ack_slots();
    // nack seen, then ack seen
    send_request(OP_WAITACK, 8'h00, 1'b0, 1'b0);
    tick(1'b1);
    tick(1'b0);
    send_request(OP_WAITACK, 8'hFF, 1'b1, 1'b1);
    tick(1'b0);
    tick(1'b1);
    send_request(OP_SENDACK, 8'h00, 1'b1, 1'b0);
    repeat (3) tick(1'b0);
    send_request(OP_SENDACK, 8'hFF, 1'b0, 1'b1);
    repeat (3) tick(1'b1);
  endtask

  // one primitive with random content, sometimes hit by a command while busy
  task automatic run_primitive();
    op_e op;
    int slots;
    op = op_e'($urandom_range(int'(OP_START), int'(OP_RECV)));
    case (op)
      OP_SEND: slots = 3 * BITS_PER_BYTE;
      OP_RECV: slots = 2 * BITS_PER_BYTE;
      OP_SENDACK: slots = 3;
      default: slots = 2;
    endcase
    send_request(op, pick_byte(), 1'($urandom), 1'($urandom));
    repeat (slots) begin
      if ($urandom_range(19) == 0)
        send_request(op_e'($urandom_range(int'(OP_START), int'(OP_UNUSED))),
                     pick_byte(), 1'($urandom), 1'($urandom));
      tick(1'($urandom));
    end
  endtask

  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = requests_taken + n_items;
    while (requests_taken < stop_at) begin
      if ($urandom_range(9) < 2)
        send_request(op_e'($urandom_range(7)), pick_byte(), 1'($urandom), 1'($urandom));
      else
        run_primitive();
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_left = 300;
    repeat (3) run_primitive();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_codes();
    test_start_stop_and_reject();
    test_ack_slots();
    wait_drained();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 64, 0);
    test_random_traffic(250, 0, 64);
    test_random_traffic(250, 21, 21);
    test_output_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
